/* rtl/enc_p2r_pkg.sv */
// ============================================================================
// enc_p2r_pkg
// Shared types and constants of the encoder period to rpm converter.
// ============================================================================
package enc_p2r_pkg;

    // Period counter width; the counter stops at its all-ones value.
    localparam int PERIOD_BITS = 24;

    localparam int SCALE_W  = 40;  // rpm_scale
    localparam int RPM_W    = 24;  // rpm, Q16.8
    localparam int FACTOR_W = 16;  // speed_factor, Q8.8
    localparam int SPEED_W  = 32;  // speed, Q24.8
    localparam int POUT_W   = 24;  // period as reported
    localparam int PROD_W   = RPM_W + FACTOR_W;
    localparam int FRAC_W   = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SCALE_W;

    // One quotient bit per step.
    localparam int DIV_STEPS = SCALE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [SCALE_W-1:0]  RPM_SCALE_RST    = SCALE_W'(64'd1396363636);
    localparam logic [RPM_W-1:0]    MAX_RPM_RST      = RPM_W'(32'd256000);
    localparam logic [FACTOR_W-1:0] SPEED_FACTOR_RST = FACTOR_W'(32'd2130);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_SCALE    = 2'd0,
        CFG_MAX_RPM      = 2'd1,
        CFG_SPEED_FACTOR = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic accept;    // take the input sample
        logic div_step;  // one restoring divide step
        logic finish;    // limit check, last-good update, multiply
        logic out_load;  // load the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic closing;   // current sample closes a period
        logic out_free;  // output register can take a new beat
    } t_dp_stat;

endpackage

/* rtl/encoder_period_to_rpm.sv */
// ============================================================================
// encoder_period_to_rpm
// Speed from the period between rising edges of the sampled encoder A line.
// ============================================================================
//
//  Channel   Direction  Payload
//  -------   ---------  ------------------------------------------------------
//  s_axis    in         tdata[0] enc_level, one beat per microsecond tick
//  m_axis    out        tdata rpm_value, speed_value, period_us; tuser held
//  cfg       in         write enable, register index, 40-bit data
//
//  A sample that does not close a period leaves the sequencer idle. A closing edge
//  holds off the next sample until these steps are through: the acceptance, 40
//  steps of the restoring divider (one quotient bit per cycle for the 40-bit
//  rpm_scale), the limit check and speed multiply, and the load of
//  the output register. The load waits while the previous result beat is
//  still unread. Reset is synchronous and restores the register defaults.
//
module encoder_period_to_rpm
    import enc_p2r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [0] enc_level
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [79:0]           o_m_axis_tdata,   // rpm_value, speed_value, period_us
    output logic [0:0]            o_m_axis_tuser    // [0] held
);

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [RPM_W-1:0]   rpm_value;
    logic [SPEED_W-1:0] speed_value;
    logic               held;
    logic [POUT_W-1:0]  period_us;

    enc_p2r_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    enc_p2r_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_enc_level   (i_s_axis_tdata[0]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_rpm_value   (rpm_value),
        .o_speed_value (speed_value),
        .o_held        (held),
        .o_period_us   (period_us)
    );

    assign o_m_axis_tdata = {period_us, speed_value, rpm_value};
    assign o_m_axis_tuser = held;

endmodule

/* rtl/enc_p2r_ctrl.sv */
// ============================================================================
// enc_p2r_ctrl
// Sequencer: sample acceptance, divide step count, multiply and output load.
// ============================================================================
module enc_p2r_ctrl
    import enc_p2r_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step,  n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.closing) begin
                    n_state = ST_DIV;
                    n_step  = '0;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_MUL;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_close_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_stat.closing) |=> (r_state == ST_DIV && r_step == '0))
        else $error("closing edge did not start the divider");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == STEP_W'(DIV_STEPS - 1)) |=> (r_state == ST_MUL))
        else $error("divider did not hand over to the multiply step");

    a_load_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_in_ready && !o_cmd.div_step))
        else $error("controller not idle after output load");
`endif

endmodule

/* rtl/enc_p2r_dp.sv */
// ============================================================================
// enc_p2r_dp
// Datapath: edge detector, period counter, serial divider, rpm limit check,
// speed multiplier, configuration and output registers.
// ============================================================================
module enc_p2r_dp
    import enc_p2r_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_enc_level,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [RPM_W-1:0]      o_rpm_value,
    output logic [SPEED_W-1:0]    o_speed_value,
    output logic                  o_held,
    output logic [POUT_W-1:0]     o_period_us
);

    localparam logic [PERIOD_BITS-1:0] TICK_MAX = {PERIOD_BITS{1'b1}};

    // Configuration.
    logic [SCALE_W-1:0]  r_rpm_scale;
    logic [RPM_W-1:0]    r_max_rpm;
    logic [FACTOR_W-1:0] r_speed_factor;

    // Edge and period tracking.
    logic                   r_prev_level;
    logic                   r_started;
    logic [PERIOD_BITS-1:0] r_tick;
    logic [PERIOD_BITS-1:0] n_tick;
    logic                   rising;

    // Divider.
    logic [PERIOD_BITS-1:0] r_period;
    logic [PERIOD_BITS-1:0] r_rem;
    logic [SCALE_W-1:0]     r_quo;
    logic [PERIOD_BITS:0]   shifted;
    logic [PERIOD_BITS:0]   diff;
    logic                   fits;

    // Limit check and multiply.
    logic [RPM_W-1:0]  r_last_good;
    logic [RPM_W-1:0]  rpm_sat;
    logic [RPM_W-1:0]  rpm_sel;
    logic              rpm_ok;
    logic [PROD_W-1:0] r_prod;
    logic [RPM_W-1:0]  r_rpm_out;
    logic              r_held;

    // Output register.
    logic               r_out_valid;
    logic [RPM_W-1:0]   r_out_rpm;
    logic [SPEED_W-1:0] r_out_speed;
    logic               r_out_held;
    logic [POUT_W-1:0]  r_out_period;
    logic [31:0]        period_wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpm_scale    <= RPM_SCALE_RST;
            r_max_rpm      <= MAX_RPM_RST;
            r_speed_factor <= SPEED_FACTOR_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RPM_SCALE:    r_rpm_scale    <= i_cfg_data[SCALE_W-1:0];
                CFG_MAX_RPM:      r_max_rpm      <= i_cfg_data[RPM_W-1:0];
                CFG_SPEED_FACTOR: r_speed_factor <= i_cfg_data[FACTOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign rising = i_enc_level && !r_prev_level;
    // The count saturates; it is at least one at any closing edge.
    assign n_tick = (r_started && r_tick != TICK_MAX) ? r_tick + 1'b1 : r_tick;

    assign o_stat.closing  = rising && r_started;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level <= 1'b1;
            r_started    <= 1'b0;
            r_tick       <= '0;
        end else if (i_cmd.accept) begin
            r_prev_level <= i_enc_level;
            if (rising) begin
                r_started <= 1'b1;
                r_tick    <= '0;
            end else begin
                r_tick <= n_tick;
            end
        end
    end

    // Restoring division, one quotient bit per step, MSB first.
    assign shifted = {r_rem, r_quo[SCALE_W-1]};
    assign diff    = shifted - {1'b0, r_period};
    assign fits    = shifted >= {1'b0, r_period};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_stat.closing) begin
            r_period <= n_tick;
            r_rem    <= '0;
            r_quo    <= r_rpm_scale;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? diff[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
            r_quo <= {r_quo[SCALE_W-2:0], fits};
        end
    end

    assign rpm_sat = (|r_quo[SCALE_W-1:RPM_W]) ? {RPM_W{1'b1}} : r_quo[RPM_W-1:0];
    assign rpm_ok  = rpm_sat < r_max_rpm;
    assign rpm_sel = rpm_ok ? rpm_sat : r_last_good;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_good <= '0;
        end else if (i_cmd.finish && rpm_ok) begin
            r_last_good <= rpm_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_prod    <= PROD_W'(rpm_sel) * PROD_W'(r_speed_factor);
            r_rpm_out <= rpm_sel;
            r_held    <= !rpm_ok;
        end
    end

    assign period_wide = 32'(r_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rpm    <= r_rpm_out;
            r_out_speed  <= r_prod[FRAC_W +: SPEED_W];
            r_out_held   <= r_held;
            r_out_period <= (period_wide > 32'(TICK_MAX) || period_wide > 32'hFF_FFFF)
                            ? {POUT_W{1'b1}} : period_wide[POUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rpm_value   = r_out_rpm;
    assign o_speed_value = r_out_speed;
    assign o_held        = r_out_held;
    assign o_period_us   = r_out_period;

`ifndef SYNTHESIS
    a_last_good_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_held || r_rpm_out == r_last_good))
        else $error("accepted rpm not stored as last good value");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("output load did not raise valid");
`endif

endmodule

/* tb/tb_encoder_period_to_rpm.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_encoder_period_to_rpm
// Self-checking testbench of the encoder period to rpm converter.
// ============================================================================
//
//  Feeds sampled A line levels as square waves with random high and low
//  lengths, plus runs of random noise. A scoreboard follows the edge detector,
//  the period counter and the rpm and speed arithmetic, and compares every
//  result beat field by field. Registers are changed between phases while the
//  block is idle, covering the reset values, zero and all-ones settings, and
//  limits that split the periods into accepted and held results.
//
module tb_encoder_period_to_rpm;
    import enc_p2r_pkg::*;

    localparam int LAT_WAIT  = 60;        // closing edge plus output load, with margin
    localparam int LIMIT     = 1500000;
    localparam int PHASE_LEN = 270;

    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE  = 2'd3;  // no register behind it
    localparam logic [PERIOD_BITS-1:0] TICKS_MAX = '1;

    typedef struct {
        logic [RPM_W-1:0]   rpm;
        logic [SPEED_W-1:0] speed;
        logic               held;
        logic [POUT_W-1:0]  period;
    } t_reading;

    class rpm_scoreboard;
        logic [SCALE_W-1:0]     scale;
        logic [RPM_W-1:0]       rpm_limit;
        logic [FACTOR_W-1:0]    factor;
        bit                     prev_lvl;
        bit                     armed;
        logic [PERIOD_BITS-1:0] ticks;
        logic [RPM_W-1:0]       kept_rpm;
        t_reading               readings_q[$];
        int                     errors;
        int                     checked;
        int                     held_seen;

        function new();
            scale     = RPM_SCALE_RST;
            rpm_limit = MAX_RPM_RST;
            factor    = SPEED_FACTOR_RST;
            prev_lvl  = 1'b1;
            armed     = 1'b0;
            ticks     = '0;
            kept_rpm  = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RPM_SCALE:    scale = val[SCALE_W-1:0];
                CFG_MAX_RPM:      rpm_limit = val[RPM_W-1:0];
                CFG_SPEED_FACTOR: factor = val[FACTOR_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic lvl);
            bit          rise;
            logic [63:0] per;
            logic [63:0] quot;
            logic [63:0] spd;
            t_reading    r;
            rise = lvl && !prev_lvl;
            prev_lvl = lvl;
            if (armed && ticks != TICKS_MAX)
                ticks++;
            if (rise) begin
                if (armed) begin
                    per = 64'(ticks);
                    if (per == 0)
                        per = 1;
                    quot = 64'(scale) / per;
                    if (quot > 64'hFF_FFFF)
                        quot = 64'hFF_FFFF;
                    // A rejected rpm leaves the last accepted one in place.
                    r.held = !(quot < 64'(rpm_limit));
                    if (!r.held)
                        kept_rpm = quot[RPM_W-1:0];
                    r.rpm = kept_rpm;
                    spd = (64'(kept_rpm) * 64'(factor)) >> FRAC_W;
                    r.speed = (spd > 64'hFFFF_FFFF) ? '1 : spd[SPEED_W-1:0];
                    r.period = (per > 64'hFF_FFFF) ? '1 : per[POUT_W-1:0];
                    readings_q.push_back(r);
                end else begin
                    armed = 1'b1;
                end
                ticks = '0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp) begin
                $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_beat(logic [79:0] data, logic [0:0] user);
            t_reading r;
            if (readings_q.size() == 0) begin
                $error("result beat with no closed period: rpm_value %0d period_us %0d",
                       data[23:0], data[79:56]);
                errors++;
                return;
            end
            r = readings_q.pop_front();
            checked++;
            if (r.held)
                held_seen++;
            compare_field("rpm_value", 32'(r.rpm), 32'(data[23:0]));
            compare_field("speed_value", r.speed, data[55:24]);
            compare_field("held", 32'(r.held), 32'(user[0]));
            compare_field("period_us", 32'(r.period), 32'(data[79:56]));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;   // [0] enc_level
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [79:0]           o_m_axis_tdata;        // [23:0] rpm_value, [55:24] speed_value,
                                                  // [79:56] period_us
    logic [0:0]            o_m_axis_tuser;        // [0] held

    rpm_scoreboard sb = new();
    int cycle_count = 0;
    int beats_sent = 0;
    int settings_used = 1;
    int burst_left = 1;
    bit steady = 1'b0;

    encoder_period_to_rpm dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: ready follows one of three moods, each chosen at random.
    int ready_mood = 0;
    int mood_left = 0;
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (mood_left == 0) begin
            ready_mood <= $urandom_range(0, 2);
            mood_left <= $urandom_range(100, 600);
        end else begin
            mood_left <= mood_left - 1;
        end
        case (ready_mood)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= $urandom_range(0, 1);
            default: begin
                if (stall_left != 0) begin
                    i_m_axis_tready <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    i_m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left <= $urandom_range(1, 40);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_beat(o_m_axis_tdata, o_m_axis_tuser);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_sample(i_s_axis_tdata[0]);
        end
    end

    task automatic send_level(input logic lvl);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {7'b0, lvl};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady) begin
                i_s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Upper data bits beyond a register's width are filled with noise.
    task automatic program_regs(input logic [SCALE_W-1:0] scale, input logic [RPM_W-1:0] lim,
                                input logic [FACTOR_W-1:0] fac, input bit poke_spare);
        write_one(CFG_RPM_SCALE, scale);
        write_one(CFG_MAX_RPM, {16'($urandom), lim});
        write_one(CFG_SPEED_FACTOR, {24'($urandom), fac});
        if (poke_spare)
            write_one(CFG_SPARE, {$urandom, 8'($urandom)});
        i_cfg_we <= 1'b0;
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.readings_q.size() != 0)
            @(posedge i_clk);
        repeat (LAT_WAIT) @(posedge i_clk);
    endtask

    // Mostly square waves of random shape; now and then a run of random levels.
    task automatic run_waves(input int n_beats, input int max_half);
        int stop_at;
        int hi_len;
        int lo_len;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                lo_len = $urandom_range(1, max_half);
                hi_len = $urandom_range(1, max_half);
                if ($urandom_range(0, 24) == 0)
                    lo_len = $urandom_range(100, 400);
                repeat (lo_len) send_level(1'b0);
                repeat (hi_len) send_level(1'b1);
            end else begin
                repeat ($urandom_range(1, 8)) send_level(1'($urandom));
            end
        end
    endtask

    initial begin
        logic dir_levels[23];
        logic [RPM_W-1:0] lim;

        // The first two highs are no edge, since the line is taken as high at reset.
        // Then the opening edge, and periods of 2, 6, 9 and 2 again, 2 being the
        // shortest possible.
        dir_levels = '{1, 1, 0, 1, 0, 1, 1, 1, 0, 0, 0, 1,
                       0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        steady = 1'b1;
        foreach (dir_levels[k])
            send_level(dir_levels[k]);
        drain();

        // Periods of 20 and less are held, longer ones accepted.
        program_regs(40'd5120000, 24'd256000, 16'd2130, 1'b0);
        steady = 1'b0;
        run_waves(PHASE_LEN, 20);
        drain();

        // Saturated rpm equals the all-ones limit, so every result is held.
        program_regs('1, '1, '1, 1'b1);
        steady = 1'b1;
        run_waves(PHASE_LEN, 30);
        drain();

        // Zero limit rejects everything.
        program_regs('0, '0, '0, 1'b0);
        steady = 1'b0;
        run_waves(PHASE_LEN, 12);
        drain();

        program_regs('0, 24'd1, 16'($urandom), 1'b1);
        run_waves(PHASE_LEN, 12);
        drain();

        program_regs({8'($urandom), $urandom}, 24'($urandom), 16'($urandom), 1'b0);
        run_waves(PHASE_LEN, 25);
        drain();

        // Limit near the rpm of mid-length periods, with large rpm values.
        lim = 24'($urandom_range(1, 32'hFF_FFFF));
        program_regs(40'(lim) * $urandom_range(4, 40) + 40'($urandom_range(0, lim)),
                     lim, 16'($urandom), 1'b1);
        run_waves(PHASE_LEN, 25);
        drain();

        $display("Sent %0d line samples under %0d register settings.", beats_sent,
                 settings_used);
        $display("Checked %0d speed results, %0d of them held at the last good rpm.",
                 sb.checked, sb.held_seen);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/enc_p2r_pkg.sv
rtl/enc_p2r_ctrl.sv
rtl/enc_p2r_dp.sv
rtl/encoder_period_to_rpm.sv
tb/tb_encoder_period_to_rpm.sv
